// ----- design/cbs_pkg.sv -----
// ---------------------------------------------------------------------------
// cbs_pkg: shared types and constants for the cubic Bezier sampler
// Control word carried from the front end to the point engine.
// ---------------------------------------------------------------------------
package cbs_pkg;

   localparam int COORD_W    = 32;
   localparam int STEP_W     = 6;
   localparam int MAX_STEPS_DEF = 63;
   localparam int FRAC_W     = 16;

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic        [STEP_W-1:0]  steps;
   } curve_type;

endpackage

// ----- design/cbs_front.sv -----
// ---------------------------------------------------------------------------
// cbs_front: request intake
// Caps the step count, drops empty curves, holds one curve for the back end.
// ---------------------------------------------------------------------------
module cbs_front #(
   parameter int MAX_STEPS = cbs_pkg::MAX_STEPS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  cbs_pkg::curve_type  req_curve,
   output logic                q_valid,
   output cbs_pkg::curve_type  q_curve,
   input  logic                q_pop,
   output logic                q_full
);
   import cbs_pkg::*;

   logic       valid_ff, valid_in;
   curve_type  curve_ff, curve_in;
   curve_type  capped;

   always_comb begin
      capped = req_curve;
      if (req_curve.steps > STEP_W'(MAX_STEPS))
         capped.steps = STEP_W'(MAX_STEPS);
   end

   always_comb begin
      valid_in = valid_ff;
      curve_in = curve_ff;
      if (q_pop)
         valid_in = 1'b0;
      if (accept && capped.steps != '0) begin
         valid_in = 1'b1;
         curve_in = capped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
      curve_ff <= curve_in;
   end

   assign q_valid = valid_ff;
   assign q_curve = curve_ff;
   assign q_full  = valid_ff;

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> valid_ff) else $error("pop from empty queue");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !q_pop) |-> !accept) else $error("queue overrun");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> curve_ff.steps != '0) else $error("empty curve queued");
`endif

endmodule

// ----- design/cbs_back.sv -----
// ---------------------------------------------------------------------------
// cbs_back: point engine
// Per inner point: restoring divide for t, a short pipeline of weight products
// and a sequential 4-term blend for x and y.
// ---------------------------------------------------------------------------
module cbs_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  cbs_pkg::curve_type       q_curve,
   output logic                     q_pop,
   output logic                     idle,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_point_x,
   output logic signed [31:0]       rsp_point_y,
   output logic                     rsp_last_point
);
   import cbs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_DIV, S_U, S_W1, S_W2, S_W3, S_ACC, S_EMIT, S_LAST
   } state_type;

   state_type            state_ff;
   curve_type            cur_ff;
   logic [STEP_W-1:0]    idx_ff;
   // divider: (idx*65536)/steps, 22-bit dividend
   logic [21:0]          quo_ff;
   logic [STEP_W-1:0]    rem_ff;
   logic [4:0]           bit_ff;
   logic [16:0]          t_ff, u_ff;
   logic [33:0]          uu_ff, ut_ff, tt_ff;
   logic [50:0]          w48_ff [4];
   logic [16:0]          w16_ff [4];
   logic [1:0]           k_ff;
   logic signed [66:0]   accx_ff, accy_ff;
   logic                 vld_ff, last_ff;
   logic signed [31:0]   ox_ff, oy_ff;

   logic [21:0]          dividend;
   logic [STEP_W:0]      rem_sh;
   logic signed [31:0]   px, py;
   logic signed [49:0]   prodx, prody;

   assign dividend = {idx_ff, 16'd0};
   assign rem_sh   = {rem_ff, dividend[bit_ff]};

   always_comb begin
      unique case (k_ff)
         2'd0: begin px = cur_ff.p0_x; py = cur_ff.p0_y; end
         2'd1: begin px = cur_ff.p1_x; py = cur_ff.p1_y; end
         2'd2: begin px = cur_ff.p2_x; py = cur_ff.p2_y; end
         default: begin px = cur_ff.p3_x; py = cur_ff.p3_y; end
      endcase
      prodx = $signed({1'b0, w16_ff[k_ff]}) * px;
      prody = $signed({1'b0, w16_ff[k_ff]}) * py;
   end

   function automatic logic signed [31:0] round_sat(input logic signed [66:0] a);
      logic signed [66:0] q;
      q = (a + 67'sd32768) >>> 16;
      if (q > 67'sd2147483647)       return 32'sh7FFFFFFF;
      else if (q < -67'sd2147483648) return 32'sh80000000;
      else                           return q[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         vld_ff <= (state_ff == S_FIRST) || (state_ff == S_EMIT) ||
                   (state_ff == S_LAST);
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               cur_ff   <= q_curve;
               state_ff <= S_FIRST;
            end
            S_FIRST: begin
               ox_ff <= cur_ff.p0_x; oy_ff <= cur_ff.p0_y;
               last_ff <= 1'b0;
               idx_ff <= STEP_W'(1);
               rem_ff <= '0; bit_ff <= 5'd21;
               state_ff <= (cur_ff.steps == STEP_W'(1)) ? S_LAST : S_DIV;
            end
            S_DIV: begin
               if (rem_sh >= {1'b0, cur_ff.steps}) begin
                  rem_ff <= STEP_W'(rem_sh - {1'b0, cur_ff.steps});
                  quo_ff[bit_ff] <= 1'b1;
               end else begin
                  rem_ff <= rem_sh[STEP_W-1:0];
                  quo_ff[bit_ff] <= 1'b0;
               end
               if (bit_ff == 5'd0) state_ff <= S_U;
               else bit_ff <= bit_ff - 5'd1;
            end
            S_U: begin
               t_ff <= quo_ff[16:0];
               u_ff <= 17'd65536 - quo_ff[16:0];
               state_ff <= S_W1;
            end
            S_W1: begin
               uu_ff <= u_ff * u_ff;
               ut_ff <= u_ff * t_ff;
               tt_ff <= t_ff * t_ff;
               state_ff <= S_W2;
            end
            S_W2: begin
               w48_ff[0] <= 51'(uu_ff * u_ff);
               w48_ff[1] <= 51'(uu_ff * t_ff) * 51'd3;
               w48_ff[2] <= 51'(tt_ff * u_ff) * 51'd3;
               w48_ff[3] <= 51'(tt_ff * t_ff);
               state_ff <= S_W3;
            end
            S_W3: begin
               for (int k = 0; k < 4; k++)
                  w16_ff[k] <= 17'((w48_ff[k] + 51'(64'h80000000)) >> 32);
               k_ff <= '0;
               accx_ff <= '0; accy_ff <= '0;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               accx_ff <= accx_ff + 67'(prodx);
               accy_ff <= accy_ff + 67'(prody);
               k_ff <= k_ff + 2'd1;
               if (k_ff == 2'd3) state_ff <= S_EMIT;
            end
            S_EMIT: begin
               ox_ff <= round_sat(accx_ff); oy_ff <= round_sat(accy_ff);
               last_ff <= 1'b0;
               rem_ff <= '0; bit_ff <= 5'd21;
               if (idx_ff + STEP_W'(1) == cur_ff.steps) state_ff <= S_LAST;
               else state_ff <= S_DIV;
               idx_ff <= idx_ff + STEP_W'(1);
            end
            S_LAST: begin
               ox_ff <= cur_ff.p3_x; oy_ff <= cur_ff.p3_y;
               last_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign q_pop          = (state_ff == S_IDLE) && q_valid;
   assign idle           = (state_ff == S_IDLE);
   assign rsp_valid      = vld_ff;
   assign rsp_point_x    = ox_ff;
   assign rsp_point_y    = oy_ff;
   assign rsp_last_point = last_ff;

`ifndef SYNTHESIS
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && last_ff) |-> state_ff == S_IDLE) else $error("last word not final");
   a_div_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_U |-> (quo_ff[21:16] == '0 && quo_ff[15:0] != '0))
      else $error("t out of range");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff == S_FIRST) else $error("pop without load");
`endif

endmodule

// ----- design/cubic_bezier_sampler.sv -----
// Order of work: the first point (p0) is sent from S_FIRST once the engine
// loads the curve; each inner point runs the restoring divide for t, the S_U
// step for u, 3 product stages, the 4-term blend and an emit step; the last
// point (p3) follows the final inner point. One more curve can be queued
// while the engine works, so busy rises only when that slot is taken.
// Results cannot be stalled. Reset (synchronous) empties queue and engine.
// ---------------------------------------------------------------------------
// cubic_bezier_sampler: top level
// Uniform-t sampling of a cubic Bezier curve in Q16.16.
// ---------------------------------------------------------------------------
module cubic_bezier_sampler #(
   parameter int MAX_STEPS = cbs_pkg::MAX_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_p0_x,
   input  logic signed [31:0] req_p0_y,
   input  logic signed [31:0] req_p1_x,
   input  logic signed [31:0] req_p1_y,
   input  logic signed [31:0] req_p2_x,
   input  logic signed [31:0] req_p2_y,
   input  logic signed [31:0] req_p3_x,
   input  logic signed [31:0] req_p3_y,
   input  logic [5:0]         req_step_count,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic               rsp_last_point
);
   import cbs_pkg::*;

   curve_type req_curve, q_curve;
   logic      q_valid, q_pop, q_full, eng_idle;

   assign req_curve = '{p0_x: req_p0_x, p0_y: req_p0_y, p1_x: req_p1_x,
                        p1_y: req_p1_y, p2_x: req_p2_x, p2_y: req_p2_y,
                        p3_x: req_p3_x, p3_y: req_p3_y, steps: req_step_count};

   assign busy = q_full;

   cbs_front #(.MAX_STEPS(MAX_STEPS)) u_front (
      .clock, .reset, .accept(start && !busy), .req_curve,
      .q_valid, .q_curve, .q_pop, .q_full
   );

   cbs_back u_back (
      .clock, .reset, .q_valid, .q_curve, .q_pop, .idle(eng_idle),
      .rsp_valid, .rsp_point_x, .rsp_point_y, .rsp_last_point
   );

`ifndef SYNTHESIS
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (eng_idle && !q_valid) |=> !rsp_valid) else $error("word from idle engine");
`endif

endmodule
